// ----- rtl/iupac_nucleotide_nibble_packer_unit_macros.svh -----
// assertion macros for the iupac nucleotide nibble packer checker
// depends on nothing; included by the checker file only
`ifndef IUPAC_NUCLEOTIDE_NIBBLE_PACKER_UNIT_MACROS_SVH
`define IUPAC_NUCLEOTIDE_NIBBLE_PACKER_UNIT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define INNP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("innp check failed: %m");

// next-cycle implication, held off while reset is low
`define INNP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("innp check failed: %m");

`endif

// ----- rtl/innp_pkg.sv -----
// shared types, constants and the character map of the nibble packer
// depends on nothing
package innp_pkg;

    // one-hot base codes
    localparam logic [3:0] CODE_T = 4'h1;
    localparam logic [3:0] CODE_C = 4'h2;
    localparam logic [3:0] CODE_A = 4'h4;
    localparam logic [3:0] CODE_G = 4'h8;

    // nibble write masks
    localparam logic [1:0] MASK_LOW  = 2'b01;
    localparam logic [1:0] MASK_HIGH = 2'b10;
    localparam logic [1:0] MASK_FULL = 2'b11;

    // configuration register indexes
    localparam logic REG_PATTERN_MODE = 1'b0;
    localparam logic REG_START_ODD    = 1'b1;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // one classified character in the queue
    typedef struct packed {
        logic [3:0] code;
        logic       last;
    } entry_t;

    // one result word
    typedef struct packed {
        logic [7:0] packed_byte;
        logic [1:0] nibble_mask;
        logic       last_out;
    } result_t;

    // ascii character to one-hot code, lower case folded to upper
    function automatic logic [3:0] map_char(input logic [7:0] c, input logic pat);
        logic [7:0] u;
        logic [3:0] code;
        u = c;
        if (c inside {[8'h61:8'h7a]}) u = c - 8'd32;
        code = 4'h0;
        case (u)
            "A": code = CODE_A;
            "C": code = CODE_C;
            "G": code = CODE_G;
            "T": code = CODE_T;
            default: begin
                if (pat) begin
                    case (u)
                        "R": code = CODE_A | CODE_G;
                        "Y": code = CODE_C | CODE_T;
                        "S": code = CODE_G | CODE_C;
                        "W": code = CODE_A | CODE_T;
                        "K": code = CODE_G | CODE_T;
                        "M": code = CODE_A | CODE_C;
                        "B": code = CODE_C | CODE_G | CODE_T;
                        "D": code = CODE_A | CODE_G | CODE_T;
                        "H": code = CODE_A | CODE_C | CODE_T;
                        "V": code = CODE_A | CODE_C | CODE_G;
                        "N": code = CODE_A | CODE_C | CODE_G | CODE_T;
                        default: code = 4'h0;
                    endcase
                end
            end
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/innp_front.sv -----
// front end: configuration registers, input acceptance and character mapping
// depends on innp_pkg
module innp_front (
    input  logic             aclk,
    input  logic             aresetn,
    // configuration write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic             cfg_data,
    // input word channel
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] chr
    input  logic             s_tlast,   // last
    // queue side
    output logic             push,
    output innp_pkg::entry_t push_entry,
    input  logic             queue_full,
    output logic             start_odd
);
    import innp_pkg::*;

    logic pattern_mode_reg;
    logic pattern_mode_next;
    logic start_odd_reg;
    logic start_odd_next;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_comb begin
        pattern_mode_next = pattern_mode_reg;
        start_odd_next    = start_odd_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_PATTERN_MODE: pattern_mode_next = cfg_data;
                REG_START_ODD:    start_odd_next    = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_mode_reg <= 1'b0;
            start_odd_reg    <= 1'b0;
        end else begin
            pattern_mode_reg <= pattern_mode_next;
            start_odd_reg    <= start_odd_next;
        end
    end

    // classify the character as it arrives, with the mode of the moment
    assign s_tready        = !queue_full;
    assign push            = s_tvalid && !queue_full;
    assign push_entry.code = map_char(s_tdata, pattern_mode_reg);
    assign push_entry.last = s_tlast;
    assign start_odd       = start_odd_reg;

endmodule

// ----- rtl/innp_fifo.sv -----
// short queue of classified characters between front and back
// depends on innp_pkg
module innp_fifo #(
    parameter int DEPTH = innp_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  innp_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output innp_pkg::entry_t pop_entry,
    output logic             not_empty
);
    import innp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = store_reg[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/innp_back.sv -----
// back end: pairs codes into bytes and drives the output register
// depends on innp_pkg
module innp_back (
    input  logic             aclk,
    input  logic             aresetn,
    // queue side
    input  logic             entry_valid,
    input  innp_pkg::entry_t entry,
    output logic             pop,
    input  logic             start_odd,
    // result word channel
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] packed_byte
    output logic [1:0]       m_tuser,   // [1:0] nibble_mask
    output logic             m_tlast    // last_out
);
    import innp_pkg::*;

    logic [3:0] held_code_reg;
    logic [3:0] held_code_next;
    logic       half_pending_reg;
    logic       half_pending_next;
    logic       in_sequence_reg;
    logic       in_sequence_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_reg;
    result_t    out_next;
    logic       emit;
    result_t    result;

    // take an entry whenever the output register is free or being drained
    assign pop = entry_valid && (!out_valid_reg || m_tready);

    // pairing decision for the entry at the head of the queue
    always_comb begin
        held_code_next    = held_code_reg;
        half_pending_next = half_pending_reg;
        in_sequence_next  = in_sequence_reg;
        emit              = 1'b0;
        result            = '0;
        if (!in_sequence_reg && start_odd) begin
            // odd start: first code alone in the high nibble
            emit              = 1'b1;
            result            = '{packed_byte: {entry.code, 4'h0},
                                  nibble_mask: MASK_HIGH, last_out: entry.last};
            held_code_next    = 4'h0;
            half_pending_next = 1'b0;
            in_sequence_next  = !entry.last;
        end else if (half_pending_reg) begin
            emit              = 1'b1;
            result            = '{packed_byte: {entry.code, held_code_reg},
                                  nibble_mask: MASK_FULL, last_out: entry.last};
            held_code_next    = 4'h0;
            half_pending_next = 1'b0;
            in_sequence_next  = !entry.last;
        end else if (entry.last) begin
            // unpaired final code goes out in the low nibble
            emit              = 1'b1;
            result            = '{packed_byte: {4'h0, entry.code},
                                  nibble_mask: MASK_LOW, last_out: 1'b1};
            held_code_next    = 4'h0;
            in_sequence_next  = 1'b0;
        end else begin
            held_code_next    = entry.code;
            half_pending_next = 1'b1;
            in_sequence_next  = 1'b1;
        end
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (pop && emit) begin
            out_valid_next = 1'b1;
            out_next       = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_code_reg    <= 4'h0;
            half_pending_reg <= 1'b0;
            in_sequence_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                held_code_reg    <= held_code_next;
                half_pending_reg <= half_pending_next;
                in_sequence_reg  <= in_sequence_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.packed_byte;
    assign m_tuser  = out_reg.nibble_mask;
    assign m_tlast  = out_reg.last_out;

endmodule

// ----- rtl/iupac_nucleotide_nibble_packer_unit.sv -----
// top level of the iupac nucleotide nibble packer
// depends on innp_pkg, innp_front, innp_fifo, innp_back
//
//  channel   direction  handshake            payload
//  cfg       in         cfg_valid/cfg_ready  cfg_index (0 pattern_mode, 1 start_odd), cfg_data
//  s_        in         s_tvalid/s_tready    s_tdata = chr, s_tlast = last
//  m_        out        m_tvalid/m_tready    m_tdata = packed_byte, m_tuser = nibble_mask,
//                                            m_tlast = last_out
//
// one character a cycle is accepted while the queue has room; the character that completes a
// byte is written to the queue, then the byte is loaded into the output register
// the queue of FIFO_DEPTH entries absorbs output stalls; s_tready falls only when it is full
// aresetn is synchronous: it clears the queue, the pairing state, the output valid flag and
// both configuration registers; cfg_ready is always high
module iupac_nucleotide_nibble_packer_unit #(
    parameter int FIFO_DEPTH = innp_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic       cfg_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] chr
    input  logic       s_tlast,   // last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] packed_byte
    output logic [1:0] m_tuser,   // [1:0] nibble_mask
    output logic       m_tlast    // last_out
);
    import innp_pkg::*;

    logic   push;
    entry_t push_entry;
    logic   queue_full;
    logic   pop;
    entry_t pop_entry;
    logic   queue_not_empty;
    logic   start_odd;

    // accept and classify
    innp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (queue_full),
        .start_odd  (start_odd)
    );

    // decoupling queue
    innp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .not_empty  (queue_not_empty)
    );

    // pair and emit
    innp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .entry_valid (queue_not_empty),
        .entry       (pop_entry),
        .pop         (pop),
        .start_odd   (start_odd),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ----- rtl/innp_checker.sv -----
// port-level checks on the nibble packer, bound to its top level
// depends on innp_pkg and iupac_nucleotide_nibble_packer_unit_macros.svh
`include "iupac_nucleotide_nibble_packer_unit_macros.svh"

module innp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);
    import innp_pkg::*;

    logic low_word;
    logic high_word;

    // partial words on the output
    assign low_word  = m_tvalid && (m_tuser == MASK_LOW);
    assign high_word = m_tvalid && (m_tuser == MASK_HIGH);

    // a word always writes at least one nibble
    `INNP_ASSERT_IMP(a_mask_nonzero, aclk, aresetn, m_tvalid, m_tuser != 2'b00)

    // a low-only word ends a sequence and leaves its high nibble clear
    `INNP_ASSERT_IMP(a_low_only_last, aclk, aresetn, low_word, m_tlast && (m_tdata[7:4] == 4'h0))

    // a high-only word leaves its low nibble clear
    `INNP_ASSERT_IMP(a_high_only_clear, aclk, aresetn, high_word, m_tdata[3:0] == 4'h0)

    // a stalled word stays offered
    `INNP_ASSERT_NXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

endmodule

bind iupac_nucleotide_nibble_packer_unit innp_checker u_innp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- verif/tb_top.sv -----
// self-checking bench for the iupac nucleotide nibble packer: directed runs, then random
// sequences under several register settings, with random source gaps and sink stalls
// depends on innp_pkg and iupac_nucleotide_nibble_packer_unit
`timescale 1ns / 1ps

module tb_top;
    import innp_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_CHARS  = 54;

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic       cfg_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] chr
    logic       s_tlast;    // last
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] packed_byte
    logic [1:0] m_tuser;    // [1:0] nibble_mask
    logic       m_tlast;    // last_out

    // idling switches, changed per phase
    bit src_gaps_on;
    bit sink_stalls_on;

    // predicts packed bytes from accepted characters and checks the output words
    class nibble_pack_scoreboard;
        bit         pattern_on;
        bit         odd_start;
        logic [3:0] held_code;
        bit         half_pending;
        bit         in_sequence;
        result_t    expected_bytes[$];
        int unsigned fail_count;

        function new();
            pattern_on   = 1'b0;
            odd_start    = 1'b0;
            held_code    = 4'h0;
            half_pending = 1'b0;
            in_sequence  = 1'b0;
            fail_count   = 0;
        endfunction

        function void write_reg(logic idx, logic val);
            if (idx == REG_PATTERN_MODE) begin
                pattern_on = val;
            end else if (idx == REG_START_ODD) begin
                odd_start = val;
            end
        endfunction

        // one-hot code; in pattern mode each base bit is set by the letters that contain it
        function logic [3:0] base_code(logic [7:0] chr);
            logic [7:0] up;
            logic [3:0] code;
            up   = (chr >= 8'h61 && chr <= 8'h7a) ? (chr & 8'hdf) : chr;
            code = 4'h0;
            if (!pattern_on) begin
                case (up)
                    "A": code = CODE_A;
                    "C": code = CODE_C;
                    "G": code = CODE_G;
                    "T": code = CODE_T;
                    default: code = 4'h0;
                endcase
            end else begin
                if (up inside {"T", "Y", "W", "K", "B", "D", "H", "N"}) code |= CODE_T;
                if (up inside {"C", "Y", "S", "M", "B", "H", "V", "N"}) code |= CODE_C;
                if (up inside {"A", "R", "W", "M", "D", "H", "V", "N"}) code |= CODE_A;
                if (up inside {"G", "R", "S", "K", "B", "D", "V", "N"}) code |= CODE_G;
            end
            return code;
        endfunction

        function void push_byte(logic [7:0] pbyte, logic [1:0] mask, logic last);
            result_t r;
            r.packed_byte = pbyte;
            r.nibble_mask = mask;
            r.last_out    = last;
            expected_bytes.push_back(r);
        endfunction

        // accepted character: advance the pairing state, maybe expect a byte
        function void note_char(logic [7:0] chr, logic last);
            logic [3:0] code;
            code = base_code(chr);
            if (!in_sequence && odd_start) begin
                // odd start: first character alone in the high nibble
                half_pending = 1'b0;
                held_code    = 4'h0;
                in_sequence  = !last;
                push_byte({code, 4'h0}, MASK_HIGH, last);
            end else if (half_pending) begin
                push_byte({code, held_code}, MASK_FULL, last);
                half_pending = 1'b0;
                held_code    = 4'h0;
                in_sequence  = !last;
            end else if (last) begin
                // unpaired final character goes out in the low nibble
                in_sequence = 1'b0;
                held_code   = 4'h0;
                push_byte({4'h0, code}, MASK_LOW, 1'b1);
            end else begin
                held_code    = code;
                half_pending = 1'b1;
                in_sequence  = 1'b1;
            end
        endfunction

        function void check_byte(logic [7:0] pbyte, logic [1:0] mask, logic last);
            result_t exp_r;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual byte %h mask %b last %b",
                         $time, pbyte, mask, last);
                fail_count++;
                return;
            end
            exp_r = expected_bytes.pop_front();
            if (pbyte !== exp_r.packed_byte) begin
                $display("%0t: packed_byte expected %h actual %h",
                         $time, exp_r.packed_byte, pbyte);
                fail_count++;
            end
            if (mask !== exp_r.nibble_mask) begin
                $display("%0t: nibble_mask expected %b actual %b",
                         $time, exp_r.nibble_mask, mask);
                fail_count++;
            end
            if (last !== exp_r.last_out) begin
                $display("%0t: last_out expected %b actual %b", $time, exp_r.last_out, last);
                fail_count++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    nibble_pack_scoreboard sb;

    iupac_nucleotide_nibble_packer_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // clock
    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    // one character word, entered and left at a falling edge; tvalid stays high on return
    task automatic send_char(logic [7:0] chr, logic last);
        int unsigned gap;
        gap = src_gaps_on ? $urandom_range(0, 5) : 0;
        repeat (gap) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = chr;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        sb.note_char(chr, last);
        @(negedge aclk);
    endtask

    task automatic send_run(string seq);
        for (int i = 0; i < seq.len(); i++) begin
            send_char(seq[i], i == seq.len() - 1);
        end
    endtask

    // sender holds off until all bytes are out and the pipeline has settled
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // mostly bases, then ambiguity letters, then any byte at all
    function automatic logic [7:0] pick_char();
        string letters;
        int unsigned roll;
        letters = "ACGTacgtRYSWKMBDHVNryswkmbdhvn";
        roll    = $urandom_range(0, 99);
        if (roll < 55) return letters[$urandom_range(0, 7)];
        if (roll < 85) return letters[$urandom_range(8, letters.len() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    // output sink with random stalls per word
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = sink_stalls_on ? $urandom_range(0, 5) : 0;
            if (stall != 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // output monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_byte(m_tdata, m_tuser, m_tlast);
        end
    end

    // stimulus
    initial begin
        int unsigned phase_count;
        int unsigned seq_len;
        sb             = new();
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_PATTERN_MODE;
        cfg_data       = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        s_tlast        = 1'b0;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: cased bases, an ambiguity letter, byte extremes, unpaired final
        send_char("A", 1'b0);
        send_char("c", 1'b0);
        send_char("G", 1'b0);
        send_char("t", 1'b0);
        send_char("N", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b1);
        wait_drained();

        // every ambiguity letter in pattern mode, odd start
        write_reg(REG_PATTERN_MODE, 1'b1);
        write_reg(REG_START_ODD, 1'b1);
        send_run("RYSWKMBDHVN");
        wait_drained();

        // one-character sequences: odd start with last, then unpaired final
        send_run("z");
        wait_drained();
        write_reg(REG_START_ODD, 1'b0);
        send_run("g");
        wait_drained();

        // register writes while a character is held: start parity must not apply
        send_char("a", 1'b0);
        wait_drained();
        write_reg(REG_START_ODD, 1'b1);
        write_reg(REG_PATTERN_MODE, 1'b0);
        send_char("n", 1'b1);
        wait_drained();

        // random sequences; a phase may end inside a sequence
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p < 4) begin
                write_reg(REG_PATTERN_MODE, p[0]);
                write_reg(REG_START_ODD, p[1]);
            end else begin
                write_reg(REG_PATTERN_MODE, 1'($urandom_range(0, 1)));
                write_reg(REG_START_ODD, 1'($urandom_range(0, 1)));
            end
            src_gaps_on    = (p % 3 != 2);
            sink_stalls_on = (p % 4 != 3);
            phase_count    = 0;
            while (phase_count < PHASE_CHARS) begin
                seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                      : $urandom_range(1, 16);
                for (int k = 0; k < seq_len && phase_count < PHASE_CHARS; k++) begin
                    if ($urandom_range(0, 39) == 0) wait_drained();
                    send_char(pick_char(), k == seq_len - 1);
                    phase_count++;
                end
            end
            wait_drained();
        end

        // end of run
        wait_drained();
        if (sb.fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
